### rtl/ijrb_pkg.sv
// Shared types, codes and constants of the input jitter reorder buffer.
`timescale 1ns / 1ps

package ijrb_pkg;

   // Default depth of the reorder window, in commands.
   localparam int DEFAULT_WINDOW = 64;

   // Field widths.
   localparam int SEQ_W = 32;
   localparam int PAY_W = 64;

   // Configuration port geometry.
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;
   localparam int REG_IDX_W  = CSR_ADDR_W - 2;

   // Item modes.
   localparam logic [1:0] MODE_COMMAND   = 2'd0;
   localparam logic [1:0] MODE_MALFORMED = 2'd1;
   localparam logic [1:0] MODE_TICK      = 2'd2;

   // Result status codes.
   localparam logic [2:0] STATUS_STORED   = 3'd0;
   localparam logic [2:0] STATUS_STALE    = 3'd1;
   localparam logic [2:0] STATUS_AHEAD    = 3'd2;
   localparam logic [2:0] STATUS_RATE     = 3'd3;
   localparam logic [2:0] STATUS_FRESH    = 3'd4;
   localparam logic [2:0] STATUS_REPEATED = 3'd5;
   localparam logic [2:0] STATUS_JUMPED   = 3'd6;

   // Register indexes on the configuration port.
   localparam logic [REG_IDX_W-1:0] REG_RATE_LIMIT   = 2'd0;
   localparam logic [REG_IDX_W-1:0] REG_BAD_LIMIT    = 2'd1;
   localparam logic [REG_IDX_W-1:0] REG_STARVE_LIMIT = 2'd2;
   localparam logic [REG_IDX_W-1:0] REG_RATE_PERIOD  = 2'd3;

   // Register reset values.
   localparam logic [15:0] RATE_LIMIT_RST   = 16'd200;
   localparam logic [7:0]  BAD_LIMIT_RST    = 8'd10;
   localparam logic [7:0]  STARVE_LIMIT_RST = 8'd6;
   localparam logic [15:0] RATE_PERIOD_RST  = 16'd60;

   // One input item.
   typedef struct packed {
      logic [1:0]       mode;
      logic             first_in_packet;
      logic [SEQ_W-1:0] sequence_req;
      logic [SEQ_W-1:0] newest_seq;
      logic [PAY_W-1:0] payload;
   } req_type;

   // One result item.
   typedef struct packed {
      logic [2:0]       status;
      logic             kick;
      logic [PAY_W-1:0] command_payload;
      logic [SEQ_W-1:0] processed_sequence;
   } rsp_type;

   // Configuration register contents.
   typedef struct packed {
      logic [15:0] rate_limit;
      logic [7:0]  bad_limit;
      logic [7:0]  starve_limit;
      logic [15:0] rate_period;
   } cfg_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic accept;
      logic check;
      logic scan_rd;
      logic scan_test;
      logic clear_step;
   } ctl_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic out_free;
      logic mem_needed;
      logic clear_last;
      logic jump_start;
      logic scan_found;
   } ctl_stat_type;

endpackage

### rtl/ijrb_csr.sv
// Configuration registers of the jitter buffer behind an APB-style port.
`timescale 1ns / 1ps

module ijrb_csr import ijrb_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready,
   output cfg_type               cfg
);

   cfg_type                cfg_ff;
   cfg_type                cfg_in;
   logic                   wr_en;
   logic [REG_IDX_W-1:0]   reg_idx;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;
   assign reg_idx    = csr_paddr[CSR_ADDR_W-1:2];
   assign cfg        = cfg_ff;

   // Register write decode.
   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (reg_idx)
            REG_RATE_LIMIT:   cfg_in.rate_limit   = csr_pwdata[15:0];
            REG_BAD_LIMIT:    cfg_in.bad_limit    = csr_pwdata[7:0];
            REG_STARVE_LIMIT: cfg_in.starve_limit = csr_pwdata[7:0];
            REG_RATE_PERIOD:  cfg_in.rate_period  = csr_pwdata[15:0];
            default: ;
         endcase
      end
   end

   // Register read mux.
   always_comb begin
      case (reg_idx)
         REG_RATE_LIMIT:   csr_prdata = CSR_DATA_W'(cfg_ff.rate_limit);
         REG_BAD_LIMIT:    csr_prdata = CSR_DATA_W'(cfg_ff.bad_limit);
         REG_STARVE_LIMIT: csr_prdata = CSR_DATA_W'(cfg_ff.starve_limit);
         REG_RATE_PERIOD:  csr_prdata = CSR_DATA_W'(cfg_ff.rate_period);
         default:          csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.rate_limit   <= RATE_LIMIT_RST;
         cfg_ff.bad_limit    <= BAD_LIMIT_RST;
         cfg_ff.starve_limit <= STARVE_LIMIT_RST;
         cfg_ff.rate_period  <= RATE_PERIOD_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

### rtl/ijrb_ctrl.sv
// Controller state machine that sequences each item through the datapath.
`timescale 1ns / 1ps

module ijrb_ctrl import ijrb_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   input  ctl_stat_type stat,
   output ctl_cmd_type  cmd,
   output logic         req_stall
);

   typedef enum logic [4:0] {
      ST_CLEAR    = 5'b00001,
      ST_IDLE     = 5'b00010,
      ST_CHECK    = 5'b00100,
      ST_SCAN_RD  = 5'b01000,
      ST_SCAN_CHK = 5'b10000
   } state_type;

   state_type state_ff;
   state_type state_in;

   // Next state and commands.
   always_comb begin
      cmd       = '0;
      req_stall = 1'b1;
      state_in  = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            cmd.clear_step = 1'b1;
            if (stat.clear_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_stall = !stat.out_free;
            if (req_valid && stat.out_free) begin
               cmd.accept = 1'b1;
               if (stat.mem_needed) begin
                  state_in = ST_CHECK;
               end
            end
         end
         ST_CHECK: begin
            cmd.check = 1'b1;
            state_in  = stat.jump_start ? ST_SCAN_RD : ST_IDLE;
         end
         ST_SCAN_RD: begin
            cmd.scan_rd = 1'b1;
            state_in    = ST_SCAN_CHK;
         end
         ST_SCAN_CHK: begin
            cmd.scan_test = 1'b1;
            state_in      = stat.scan_found ? ST_IDLE : ST_SCAN_RD;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

### rtl/ijrb_datapath.sv
// Datapath of the jitter buffer: slot memory, sequence state, counters, result register.
`timescale 1ns / 1ps

module ijrb_datapath import ijrb_pkg::*; #(
   parameter int WINDOW = DEFAULT_WINDOW
) (
   input  logic         clock,
   input  logic         reset,
   input  cfg_type      cfg,
   input  req_type      req_data,
   input  logic         rsp_stall,
   output logic         rsp_valid,
   output rsp_type      rsp_data,
   input  ctl_cmd_type  cmd,
   output ctl_stat_type stat
);

   localparam int IDX_W = $clog2(WINDOW);
   localparam int CNT_W = $clog2(WINDOW + 1);
   localparam logic [IDX_W:0]   WIN_EXT  = (IDX_W + 1)'(WINDOW);
   localparam logic [IDX_W:0]   ONE_EXT  = (IDX_W + 1)'(1);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(WINDOW - 1);

   // Slot index arithmetic: base plus a distance of at most one window.
   function automatic logic [IDX_W-1:0] wrap_add(input logic [IDX_W-1:0] base,
                                                 input logic [IDX_W:0]   step);
      logic [IDX_W:0] sum;
      sum = {1'b0, base} + step;
      if (sum >= WIN_EXT) begin
         sum = sum - WIN_EXT;
      end
      return sum[IDX_W-1:0];
   endfunction

   // Slot memory: valid bit above the payload.
   logic [PAY_W:0]       slot_ff [WINDOW];
   logic [PAY_W:0]       rd_ff;
   logic                 mem_we;
   logic [IDX_W-1:0]     mem_waddr;
   logic [PAY_W:0]       mem_wdata;
   logic [IDX_W-1:0]     mem_raddr;

   // Sequence and counter state.
   logic [SEQ_W-1:0]     lp_ff, lp_in;
   logic [IDX_W-1:0]     base_ff, base_in;
   logic [CNT_W-1:0]     held_ff, held_in;
   logic [7:0]           starved_ff, starved_in;
   logic [15:0]          pc_ff, pc_in;
   logic [7:0]           bad_ff, bad_in;
   logic [15:0]          phase_ff, phase_in;
   logic                 dropped_ff, dropped_in;
   logic [PAY_W-1:0]     last_pay_ff, last_pay_in;
   logic [IDX_W-1:0]     clr_ptr_ff, clr_ptr_in;
   logic                 rsp_valid_ff, rsp_valid_in;

   // Item in flight and jump scan.
   logic [PAY_W-1:0]     item_pay_ff, item_pay_in;
   logic                 item_tick_ff, item_tick_in;
   logic [IDX_W-1:0]     item_idx_ff, item_idx_in;
   logic [IDX_W-1:0]     scan_ptr_ff, scan_ptr_in;
   logic [SEQ_W-1:0]     scan_seq_ff, scan_seq_in;
   rsp_type              rsp_ff, rsp_in;
   logic                 out_load;

   // Decode of the offered item.
   logic                 is_cmd, is_bad, is_tick, acc_first, over, drop_now, mem_needed;
   logic [15:0]          pc_inc;
   logic [7:0]           bad_inc;
   logic [2:0]           imm_status;
   logic                 imm_kick;
   logic [SEQ_W:0]       limit_ext;
   logic [IDX_W:0]       seq_dist;
   logic [IDX_W-1:0]     store_idx, tick_idx, acc_idx;

   // Slot check.
   logic                 slot_hit;
   logic [PAY_W-1:0]     slot_pay;
   logic [7:0]           st_inc;
   logic                 chk_jump;
   logic [15:0]          phase_inc;
   logic                 period_end;

   assign limit_ext = {1'b0, lp_ff} + (SEQ_W + 1)'(WINDOW);
   assign seq_dist  = req_data.sequence_req[IDX_W:0] - lp_ff[IDX_W:0];
   assign store_idx = wrap_add(base_ff, seq_dist);
   assign tick_idx  = wrap_add(base_ff, ONE_EXT);

   // Classification of the offered item; only commands in the window and ticks need the memory.
   always_comb begin
      is_cmd     = (req_data.mode == MODE_COMMAND);
      is_bad     = (req_data.mode == MODE_MALFORMED);
      is_tick    = (req_data.mode == MODE_TICK);
      acc_first  = is_cmd && req_data.first_in_packet;
      pc_inc     = (pc_ff == 16'hFFFF) ? pc_ff : pc_ff + 16'd1;
      bad_inc    = (bad_ff == 8'hFF) ? bad_ff : bad_ff + 8'd1;
      over       = pc_inc > cfg.rate_limit;
      drop_now   = acc_first ? over : dropped_ff;
      acc_idx    = is_tick ? tick_idx : store_idx;
      imm_status = STATUS_STALE;
      imm_kick   = 1'b0;
      mem_needed = 1'b0;
      case (req_data.mode)
         MODE_COMMAND: begin
            if (drop_now) begin
               imm_status = STATUS_RATE;
               imm_kick   = acc_first && over;
            end else if ({1'b0, req_data.newest_seq} > limit_ext) begin
               imm_status = STATUS_AHEAD;
            end else if (req_data.sequence_req <= lp_ff) begin
               imm_status = STATUS_STALE;
            end else if ({1'b0, req_data.sequence_req} > limit_ext) begin
               imm_status = STATUS_AHEAD;
            end else begin
               mem_needed = 1'b1;
            end
         end
         MODE_MALFORMED: begin
            if (over) begin
               imm_status = STATUS_RATE;
               imm_kick   = 1'b1;
            end else begin
               imm_status = STATUS_STALE;
               imm_kick   = bad_inc > cfg.bad_limit;
            end
         end
         MODE_TICK: begin
            mem_needed = 1'b1;
         end
         default: ;
      endcase
   end

   // Slot check terms for the item in flight.
   always_comb begin
      slot_hit   = rd_ff[PAY_W];
      slot_pay   = rd_ff[PAY_W-1:0];
      st_inc     = (starved_ff == 8'hFF) ? starved_ff : starved_ff + 8'd1;
      chk_jump   = item_tick_ff && !slot_hit && (held_ff != '0) &&
                   (st_inc >= cfg.starve_limit);
      phase_inc  = phase_ff + 16'd1;
      period_end = phase_inc >= cfg.rate_period;
   end

   // Next state of the datapath under the controller's commands.
   always_comb begin
      lp_in        = lp_ff;
      base_in      = base_ff;
      held_in      = held_ff;
      starved_in   = starved_ff;
      pc_in        = pc_ff;
      bad_in       = bad_ff;
      phase_in     = phase_ff;
      dropped_in   = dropped_ff;
      last_pay_in  = last_pay_ff;
      clr_ptr_in   = clr_ptr_ff;
      item_pay_in  = item_pay_ff;
      item_tick_in = item_tick_ff;
      item_idx_in  = item_idx_ff;
      scan_ptr_in  = scan_ptr_ff;
      scan_seq_in  = scan_seq_ff;
      rsp_in       = rsp_ff;
      out_load     = 1'b0;
      mem_we       = 1'b0;
      mem_waddr    = clr_ptr_ff;
      mem_wdata    = '0;
      mem_raddr    = cmd.scan_rd ? scan_ptr_ff : acc_idx;

      // Clearing pass over the slot memory after reset.
      if (cmd.clear_step) begin
         mem_we     = 1'b1;
         mem_waddr  = clr_ptr_ff;
         clr_ptr_in = clr_ptr_ff + IDX_W'(1);
      end

      // Accepted item: update rate state, finish at once unless a slot is needed.
      if (cmd.accept) begin
         item_pay_in  = req_data.payload;
         item_tick_in = is_tick;
         item_idx_in  = acc_idx;
         if (acc_first || is_bad) begin
            pc_in = pc_inc;
         end
         if (acc_first) begin
            dropped_in = over;
         end
         if (is_bad) begin
            dropped_in = 1'b1;
            if (!over) begin
               bad_in = bad_inc;
            end
         end
         if (!mem_needed) begin
            out_load                  = 1'b1;
            rsp_in.status             = imm_status;
            rsp_in.kick               = imm_kick;
            rsp_in.command_payload    = '0;
            rsp_in.processed_sequence = lp_ff;
         end
      end

      // Slot read is back: store a command or call it stale, or for a tick pick, repeat or start a jump.
      if (cmd.check) begin
         rsp_in.kick               = 1'b0;
         rsp_in.command_payload    = '0;
         rsp_in.processed_sequence = lp_ff;
         if (item_tick_ff) begin
            phase_in    = period_end ? 16'd0 : phase_inc;
            pc_in       = period_end ? 16'd0 : pc_ff;
            scan_ptr_in = wrap_add(item_idx_ff, ONE_EXT);
            scan_seq_in = lp_ff + SEQ_W'(2);
            if (slot_hit) begin
               mem_we                    = 1'b1;
               mem_waddr                 = item_idx_ff;
               lp_in                     = lp_ff + SEQ_W'(1);
               base_in                   = item_idx_ff;
               starved_in                = 8'd0;
               held_in                   = held_ff - CNT_W'(1);
               last_pay_in               = slot_pay;
               out_load                  = 1'b1;
               rsp_in.status             = STATUS_FRESH;
               rsp_in.command_payload    = slot_pay;
               rsp_in.processed_sequence = lp_ff + SEQ_W'(1);
            end else if (chk_jump) begin
               starved_in = 8'd0;
            end else begin
               if (held_ff != '0) begin
                  starved_in = st_inc;
               end
               out_load               = 1'b1;
               rsp_in.status          = STATUS_REPEATED;
               rsp_in.command_payload = last_pay_ff;
            end
         end else begin
            out_load = 1'b1;
            if (slot_hit) begin
               rsp_in.status = STATUS_STALE;
            end else begin
               mem_we        = 1'b1;
               mem_waddr     = item_idx_ff;
               mem_wdata     = {1'b1, item_pay_ff};
               held_in       = held_ff + CNT_W'(1);
               rsp_in.status = STATUS_STORED;
            end
         end
      end

      // Jump scan: take the oldest held command.
      if (cmd.scan_test) begin
         if (slot_hit) begin
            mem_we                    = 1'b1;
            mem_waddr                 = scan_ptr_ff;
            lp_in                     = scan_seq_ff;
            base_in                   = scan_ptr_ff;
            held_in                   = held_ff - CNT_W'(1);
            last_pay_in               = slot_pay;
            out_load                  = 1'b1;
            rsp_in.status             = STATUS_JUMPED;
            rsp_in.kick               = 1'b0;
            rsp_in.command_payload    = slot_pay;
            rsp_in.processed_sequence = scan_seq_ff;
         end else begin
            scan_ptr_in = wrap_add(scan_ptr_ff, ONE_EXT);
            scan_seq_in = scan_seq_ff + SEQ_W'(1);
         end
      end

      rsp_valid_in = out_load || (rsp_valid_ff && rsp_stall);
   end

   // Status toward the controller.
   assign stat.out_free   = !rsp_valid_ff || !rsp_stall;
   assign stat.mem_needed = mem_needed;
   assign stat.clear_last = (clr_ptr_ff == LAST_IDX);
   assign stat.jump_start = chk_jump;
   assign stat.scan_found = slot_hit;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // Slot memory with registered read.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         slot_ff[mem_waddr] <= mem_wdata;
      end
      rd_ff <= slot_ff[mem_raddr];
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         lp_ff        <= '0;
         base_ff      <= '0;
         held_ff      <= '0;
         starved_ff   <= '0;
         pc_ff        <= '0;
         bad_ff       <= '0;
         phase_ff     <= '0;
         dropped_ff   <= 1'b0;
         last_pay_ff  <= '0;
         clr_ptr_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         lp_ff        <= lp_in;
         base_ff      <= base_in;
         held_ff      <= held_in;
         starved_ff   <= starved_in;
         pc_ff        <= pc_in;
         bad_ff       <= bad_in;
         phase_ff     <= phase_in;
         dropped_ff   <= dropped_in;
         last_pay_ff  <= last_pay_in;
         clr_ptr_ff   <= clr_ptr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      item_pay_ff  <= item_pay_in;
      item_tick_ff <= item_tick_in;
      item_idx_ff  <= item_idx_in;
      scan_ptr_ff  <= scan_ptr_in;
      scan_seq_ff  <= scan_seq_in;
      rsp_ff       <= rsp_in;
   end

endmodule

### rtl/input_jitter_reorder_buffer.sv
// Top level of the input jitter reorder buffer for one player.
`timescale 1ns / 1ps

// The req channel carries one item per transfer: a command of a packet, a
// malformed-packet notice, or a simulation tick. The rsp channel returns
// exactly one result per item, in order. Both use valid and stall.
// Registers rate_limit, bad_limit, starve_limit and rate_period sit at byte
// addresses 0, 4, 8 and 12 of the csr port; write them only while idle.
// Rate-dropped and malformed packets, the unused mode, and stale or
// ahead-of-window commands finish at the transfer edge: the result is valid
// in the next cycle; one such item is taken each cycle unless rsp stalls.
// A command that lands in the window and every tick need a read-modify-write
// of the slot memory after its registered read; the next item waits for it.
// A tick that jumps to the oldest held command scans the memory slot by
// slot, with a read state and then a test state for each slot.
// After reset the block writes every slot of the slot memory invalid with
// req_stall high. While rsp_stall holds a result, no further item is taken,
// and req_stall stays high until the result leaves.

module input_jitter_reorder_buffer import ijrb_pkg::*; #(
   parameter int WINDOW = DEFAULT_WINDOW
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  req_type               req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rsp_type               rsp_data,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   cfg_type      cfg;
   ctl_cmd_type  cmd;
   ctl_stat_type stat;

   ijrb_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   ijrb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .stat      (stat),
      .cmd       (cmd),
      .req_stall (req_stall)
   );

   ijrb_datapath #(
      .WINDOW (WINDOW)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .req_data  (req_data),
      .rsp_stall (rsp_stall),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .cmd       (cmd),
      .stat      (stat)
   );

endmodule
